// ===== sv/mmt_pkg.sv =====
package mmt_pkg;

    localparam int MAX_DIM_N = 64;
    localparam int DIM_W     = 7;
    localparam int IDX_W     = 6;
    localparam int ADDR_W    = 12;
    localparam int DEPTH     = MAX_DIM_N * MAX_DIM_N;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 40;
    localparam int QDEPTH    = 2;

    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_DIM_N);

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] MODE_A_T = 2'd1;
    localparam logic [1:0] MODE_B_T = 2'd2;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_ROWS_M  = 2'd1;
    localparam logic [1:0] REG_INNER_K = 2'd2;
    localparam logic [1:0] REG_COLS_N  = 2'd3;

    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_BAD    = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic [ELEM_W-1:0] value;
        logic [DIM_W-1:0]  a_step;
        logic [DIM_W-1:0]  b_step;
        logic [DIM_W-1:0]  count;
    } item_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > MAX_DIM)
            r = MAX_DIM;
        return r;
    endfunction

endpackage

// ===== sv/mmt_front.sv =====
module mmt_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [mmt_pkg::DIM_W-1:0]       cfg_data,
    input  logic [1:0]                      action,
    input  logic [mmt_pkg::ADDR_W-1:0]      position,
    input  logic signed [mmt_pkg::ELEM_W-1:0] value,
    input  logic [mmt_pkg::IDX_W-1:0]       row,
    input  logic [mmt_pkg::IDX_W-1:0]       col,
    output logic                            push,
    output mmt_pkg::item_t                  item
);
    import mmt_pkg::*;

    logic [1:0]       mode_reg;
    logic [DIM_W-1:0] rows_m_reg;
    logic [DIM_W-1:0] inner_k_reg;
    logic [DIM_W-1:0] cols_n_reg;

    logic [2*DIM_W-1:0]   mk;
    logic [2*DIM_W-1:0]   kn;
    logic [ADDR_W:0]      rk;
    logic [ADDR_W:0]      ck;
    logic                 bad;
    logic                 keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            rows_m_reg  <= MAX_DIM;
            inner_k_reg <= MAX_DIM;
            cols_n_reg  <= MAX_DIM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[1:0];
                REG_ROWS_M:  rows_m_reg  <= clamp_dim(cfg_data);
                REG_INNER_K: inner_k_reg <= clamp_dim(cfg_data);
                REG_COLS_N:  cols_n_reg  <= clamp_dim(cfg_data);
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    assign mk = (2*DIM_W)'(rows_m_reg) * (2*DIM_W)'(inner_k_reg);
    assign kn = (2*DIM_W)'(inner_k_reg) * (2*DIM_W)'(cols_n_reg);
    assign rk = (ADDR_W+1)'(row) * (ADDR_W+1)'(inner_k_reg);
    assign ck = (ADDR_W+1)'(col) * (ADDR_W+1)'(inner_k_reg);
    assign bad = (DIM_W'(row) >= rows_m_reg) || (DIM_W'(col) >= cols_n_reg);

    always_comb
    begin
        item        = '0;
        item.value  = value;
        item.count  = inner_k_reg;
        keep        = 1'b0;
        unique case (action)
            ACT_LOAD_A:
            begin
                item.kind   = KIND_LOAD_A;
                item.a_addr = position;
                keep        = (2*DIM_W)'(position) < mk;
            end
            ACT_LOAD_B:
            begin
                item.kind   = KIND_LOAD_B;
                item.a_addr = position;
                keep        = (2*DIM_W)'(position) < kn;
            end
            ACT_QUERY:
            begin
                keep        = 1'b1;
                item.kind   = bad ? KIND_BAD : KIND_QUERY;
                item.a_addr = (mode_reg == MODE_A_T) ? ADDR_W'(row) : rk[ADDR_W-1:0];
                item.a_step = (mode_reg == MODE_A_T) ? rows_m_reg : DIM_W'(1);
                item.b_addr = (mode_reg == MODE_B_T) ? ck[ADDR_W-1:0] : ADDR_W'(col);
                item.b_step = (mode_reg == MODE_B_T) ? DIM_W'(1) : cols_n_reg;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

endmodule

// ===== sv/mmt_queue.sv =====
module mmt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mmt_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output mmt_pkg::item_t head
);
    import mmt_pkg::*;

    item_t      slot_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'(QDEPTH));
    assign empty   = (count_reg == 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/mmt_back.sv =====
module mmt_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              empty,
    input  mmt_pkg::item_t                    head,
    output logic                              pop,
    output logic                              done,
    output logic signed [mmt_pkg::PROD_W-1:0] product,
    output logic                              saturated,
    output logic                              bad_index
);
    import mmt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh8000_0000);

    logic [ELEM_W-1:0] a_mem [DEPTH];
    logic [ELEM_W-1:0] b_mem [DEPTH];

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [ADDR_W-1:0]        a_addr_reg;
    logic [ADDR_W-1:0]        b_addr_reg;
    logic [DIM_W-1:0]         a_step_reg;
    logic [DIM_W-1:0]         b_step_reg;
    logic [DIM_W-1:0]         cnt_reg;
    logic signed [ELEM_W-1:0] a_rd_reg;
    logic signed [ELEM_W-1:0] b_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     v1_reg;
    logic                     l1_reg;
    logic                     v2_reg;
    logic                     l2_reg;
    logic                     done_reg;
    logic signed [PROD_W-1:0] product_reg;
    logic                     sat_reg;
    logic                     bad_reg;

    logic signed [ACC_W-1:0]  sum;
    logic                     take;

    assign take = (state_reg == ST_IDLE) && !empty;
    assign pop  = take;
    assign sum  = acc_reg + ACC_W'(prod_reg);

    // operand stores
    always_ff @(posedge clk)
    begin
        if (take && head.kind == KIND_LOAD_A)
            a_mem[head.a_addr] <= head.value;
        a_rd_reg <= a_mem[a_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (take && head.kind == KIND_LOAD_B)
            b_mem[head.a_addr] <= head.value;
        b_rd_reg <= b_mem[b_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_rd_reg * b_rd_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && head.kind == KIND_QUERY)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (cnt_reg == DIM_W'(1))
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (l2_reg)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            v1_reg    <= 1'b0;
            l1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            l2_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == ST_RUN);
            l1_reg    <= (state_reg == ST_RUN) && (cnt_reg == DIM_W'(1));
            v2_reg    <= v1_reg;
            l2_reg    <= l1_reg;
            done_reg  <= (take && head.kind == KIND_BAD) || l2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_addr_reg <= head.a_addr;
            b_addr_reg <= head.b_addr;
            a_step_reg <= head.a_step;
            b_step_reg <= head.b_step;
            cnt_reg    <= head.count;
            acc_reg    <= '0;
        end
        else
        begin
            if (state_reg == ST_RUN)
            begin
                a_addr_reg <= a_addr_reg + ADDR_W'(a_step_reg);
                b_addr_reg <= b_addr_reg + ADDR_W'(b_step_reg);
                cnt_reg    <= cnt_reg - DIM_W'(1);
            end
            if (v2_reg)
                acc_reg <= sum;
        end

        if (take && head.kind == KIND_BAD)
        begin
            product_reg <= '0;
            sat_reg     <= 1'b0;
            bad_reg     <= 1'b1;
        end
        else if (l2_reg)
        begin
            bad_reg <= 1'b0;
            if (sum > SAT_MAX)
            begin
                product_reg <= SAT_MAX[PROD_W-1:0];
                sat_reg     <= 1'b1;
            end
            else if (sum < SAT_MIN)
            begin
                product_reg <= SAT_MIN[PROD_W-1:0];
                sat_reg     <= 1'b1;
            end
            else
            begin
                product_reg <= sum[PROD_W-1:0];
                sat_reg     <= 1'b0;
            end
        end
    end

    assign done      = done_reg;
    assign product   = product_reg;
    assign saturated = sat_reg;
    assign bad_index = bad_reg;

endmodule

// ===== sv/matrix_multiply_transpose_modes_top.sv =====
// matrix multiply query engine, C = op(A) x op(B), Q8.8 operands, Q16.16 results
// input beats are accepted when start is high and busy is low; action picks
// load A, load B or query; loads write one element at its flat position in the
// stored layout, out-of-range loads and unused actions are taken and dropped
// config writes (cfg_we, cfg_index, cfg_data) are registered; the user makes
// them only while the block is idle, which the block itself does not enforce;
// mode picks plain, A transposed or B transposed; accepted beats go through a
// two-entry queue to the execution side, busy is high while that queue is full
// a load is written into its operand memory as the execution side takes it
// a query walks inner_k element pairs through one multiply-accumulate, one pair
// a cycle out of the two operand memories, through the registered memory reads,
// the product register and the accumulator, then strobes done; a query with a
// bad row or column strobes done without a walk, registered from its take
// the execution side takes the next item only once idle, loads one per cycle
// done is high for one cycle with product, saturated and bad_index; the
// receiver cannot stall, every result is taken as shown
// reset clears the queue and sets mode 0 and all sizes to 64; memory contents
// stay undefined until loaded
module matrix_multiply_transpose_modes_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        action,
    input  logic [mmt_pkg::ADDR_W-1:0]        position,
    input  logic signed [mmt_pkg::ELEM_W-1:0] value,
    input  logic [mmt_pkg::IDX_W-1:0]         row,
    input  logic [mmt_pkg::IDX_W-1:0]         col,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [mmt_pkg::DIM_W-1:0]         cfg_data,
    output logic                              done,
    output logic signed [mmt_pkg::PROD_W-1:0] product,
    output logic                              saturated,
    output logic                              bad_index
);
    import mmt_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    item_t push_item;
    item_t head;

    assign busy = full;

    mmt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (start && !full),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .action    (action),
        .position  (position),
        .value     (value),
        .row       (row),
        .col       (col),
        .push      (push),
        .item      (push_item)
    );

    mmt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    mmt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .done      (done),
        .product   (product),
        .saturated (saturated),
        .bad_index (bad_index)
    );

endmodule

// ===== sv/mmt_checker.sv =====
module mmt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              done,
    input logic signed [mmt_pkg::PROD_W-1:0] product,
    input logic                              saturated,
    input logic                              bad_index
);
    import mmt_pkg::*;

    ap_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(saturated && bad_index))
        else $error("saturated and bad_index both set");

    ap_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_index) |-> (product == '0))
        else $error("bad index result carries a nonzero product");

    ap_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            (product == PROD_W'(32'h7FFF_FFFF) || product == PROD_W'(32'h8000_0000)))
        else $error("saturated result not at a rail");

endmodule

bind matrix_multiply_transpose_modes_top mmt_checker u_mmt_checker (.*);
